// ===== rtl/core/spa_pkg.sv =====
// spa_pkg: shared widths, operation codes and the command structure for the
// sparse polynomial add/subtract block. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

    localparam int EXP_W       = 16;
    localparam int COEF_W      = 32;
    localparam int TERM_W      = EXP_W + COEF_W;
    localparam int MAX_TERMS   = 32;
    localparam int IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W       = $clog2(MAX_TERMS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // input mode codes
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_LOAD_A = 3'd1;
    localparam logic [2:0] MODE_LOAD_B = 3'd2;
    localparam logic [2:0] MODE_ADD    = 3'd3;
    localparam logic [2:0] MODE_SUB    = 3'd4;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_ADD,
        OP_SUB
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [EXP_W-1:0]         exponent;
        logic signed [COEF_W-1:0] coefficient;
    } t_cmd;

    // term list write port, shared by both list memories
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [IDX_W-1:0]  addr;
        logic [TERM_W-1:0] data;
    } t_list_wr;

endpackage

`default_nettype wire

// ===== rtl/core/spa_ram.sv =====
// spa_ram: generic single write port, single read port RAM with a registered
// read. Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/spa_front.sv =====
// spa_front: takes input transactions, decodes the mode into a command and
// drops unused modes. Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_front (
    input  wire logic                         i_valid,
    input  wire logic [2:0]                   i_mode,
    input  wire logic [spa_pkg::EXP_W-1:0]    i_exponent,
    input  wire logic signed [spa_pkg::COEF_W-1:0] i_coefficient,
    input  wire logic                         i_queue_full,
    output logic                              o_stall,
    output logic                              o_push,
    output spa_pkg::t_cmd                     o_cmd
);

    logic known;

    always_comb begin
        known    = 1'b1;
        o_cmd.op = spa_pkg::OP_CLEAR;
        unique case (i_mode)
            spa_pkg::MODE_CLEAR:  o_cmd.op = spa_pkg::OP_CLEAR;
            spa_pkg::MODE_LOAD_A: o_cmd.op = spa_pkg::OP_LOAD_A;
            spa_pkg::MODE_LOAD_B: o_cmd.op = spa_pkg::OP_LOAD_B;
            spa_pkg::MODE_ADD:    o_cmd.op = spa_pkg::OP_ADD;
            spa_pkg::MODE_SUB:    o_cmd.op = spa_pkg::OP_SUB;
            default:              known    = 1'b0;
        endcase
        o_cmd.exponent    = i_exponent;
        o_cmd.coefficient = i_coefficient;
    end

    // unused modes are swallowed here and never reach the queue
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full && known;

endmodule

`default_nettype wire

// ===== rtl/core/spa_cmd_fifo.sv =====
// spa_cmd_fifo: short command queue between the front and back ends.
// Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire spa_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output spa_pkg::t_cmd      o_cmd
);

    spa_pkg::t_cmd                 r_mem [spa_pkg::QUEUE_DEPTH];
    logic [spa_pkg::Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [spa_pkg::Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [spa_pkg::Q_CNT_W-1:0]   r_count, n_count;
    logic                          do_push, do_pop;

    localparam logic [spa_pkg::Q_PTR_W-1:0] LAST_PTR =
        spa_pkg::Q_PTR_W'(spa_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_count == spa_pkg::Q_CNT_W'(spa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spa_back.sv =====
// spa_back: executes queued commands - list clear and load, and the merge
// walk for add/subtract with its output register. Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire spa_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_pop,
    output spa_pkg::t_list_wr                  o_wr,
    output logic [spa_pkg::IDX_W-1:0]          o_raddr_a,
    output logic [spa_pkg::IDX_W-1:0]          o_raddr_b,
    input  wire logic [spa_pkg::TERM_W-1:0]    i_rdata_a,
    input  wire logic [spa_pkg::TERM_W-1:0]    i_rdata_b,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [spa_pkg::EXP_W-1:0]          o_out_exponent,
    output logic signed [spa_pkg::COEF_W-1:0]  o_out_coefficient,
    output logic                               o_is_empty,
    output logic                               o_is_last
);

    localparam int EW = spa_pkg::EXP_W;
    localparam int CW = spa_pkg::COEF_W;
    localparam int NW = spa_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CMP   = 5'b00100,
        S_PUSH  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    function automatic logic signed [CW-1:0] sat_coef(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] lo;
        hi = {3'b000, {(CW-1){1'b1}}};
        lo = {3'b111, {(CW-1){1'b0}}};
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    t_state                 r_state, n_state;
    logic [NW-1:0]          r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [NW-1:0]          r_i, n_i, r_j, n_j;
    logic                   r_sub, n_sub;
    logic                   r_have_pend, n_have_pend;
    logic                   r_term_nz, n_term_nz;
    logic                   r_out_valid, n_out_valid;
    logic [EW-1:0]          r_term_exp, n_term_exp, r_pend_exp, n_pend_exp;
    logic signed [CW-1:0]   r_term_coef, n_term_coef, r_pend_coef, n_pend_coef;
    logic [EW-1:0]          r_out_exp, n_out_exp;
    logic signed [CW-1:0]   r_out_coef, n_out_coef;
    logic                   r_out_empty, n_out_empty, r_out_last, n_out_last;

    logic                   has_a, has_b, take_both, take_a, out_free;
    logic [EW-1:0]          a_exp, b_exp;
    logic signed [CW+1:0]   a_ext, b_ext, b_term, raw;
    logic signed [CW-1:0]   sat;

    assign a_exp  = i_rdata_a[spa_pkg::TERM_W-1:CW];
    assign b_exp  = i_rdata_b[spa_pkg::TERM_W-1:CW];
    assign a_ext  = {{2{i_rdata_a[CW-1]}}, i_rdata_a[CW-1:0]};
    assign b_ext  = {{2{i_rdata_b[CW-1]}}, i_rdata_b[CW-1:0]};
    assign b_term = r_sub ? -b_ext : b_ext;

    assign has_a     = (r_i < r_cnt_a);
    assign has_b     = (r_j < r_cnt_b);
    assign take_both = has_a && has_b && (a_exp == b_exp);
    assign take_a    = !take_both && has_a && (!has_b || (a_exp < b_exp));
    assign raw       = take_both ? (a_ext + b_term) : (take_a ? a_ext : b_term);
    assign sat       = sat_coef(raw);

    assign out_free  = !r_out_valid || !i_stall;
    assign o_raddr_a = r_i[spa_pkg::IDX_W-1:0];
    assign o_raddr_b = r_j[spa_pkg::IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_sub       = r_sub;
        n_have_pend = r_have_pend;
        n_term_nz   = r_term_nz;
        n_term_exp  = r_term_exp;
        n_term_coef = r_term_coef;
        n_pend_exp  = r_pend_exp;
        n_pend_coef = r_pend_coef;
        n_out_valid = r_out_valid && i_stall;
        n_out_exp   = r_out_exp;
        n_out_coef  = r_out_coef;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        o_wr.we_a   = 1'b0;
        o_wr.we_b   = 1'b0;
        o_wr.addr   = r_cnt_a[spa_pkg::IDX_W-1:0];
        o_wr.data   = {i_cmd.exponent, i_cmd.coefficient};

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        spa_pkg::OP_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_b = '0;
                        end
                        spa_pkg::OP_LOAD_A: begin
                            if (r_cnt_a < NW'(spa_pkg::MAX_TERMS)) begin
                                o_wr.we_a = 1'b1;
                                n_cnt_a   = r_cnt_a + 1'b1;
                            end
                        end
                        spa_pkg::OP_LOAD_B: begin
                            o_wr.addr = r_cnt_b[spa_pkg::IDX_W-1:0];
                            if (r_cnt_b < NW'(spa_pkg::MAX_TERMS)) begin
                                o_wr.we_b = 1'b1;
                                n_cnt_b   = r_cnt_b + 1'b1;
                            end
                        end
                        spa_pkg::OP_ADD, spa_pkg::OP_SUB: begin
                            n_i         = '0;
                            n_j         = '0;
                            n_have_pend = 1'b0;
                            n_sub       = (i_cmd.op == spa_pkg::OP_SUB);
                            n_state     = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // heads at the new indices appear at the RAM outputs next cycle
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!has_a && !has_b) begin
                    n_state = S_FLUSH;
                end else begin
                    n_term_exp  = (take_both || take_a) ? a_exp : b_exp;
                    n_term_coef = sat;
                    n_term_nz   = (sat != '0);
                    if (take_both || take_a) begin
                        n_i = r_i + 1'b1;
                    end
                    if (take_both || !take_a) begin
                        n_j = r_j + 1'b1;
                    end
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // one surviving term is held back so the final one can carry last
                if (!r_term_nz) begin
                    n_state = S_CMP;
                end else if (!r_have_pend) begin
                    n_pend_exp  = r_term_exp;
                    n_pend_coef = r_term_coef;
                    n_have_pend = 1'b1;
                    n_state     = S_CMP;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_exp   = r_pend_exp;
                    n_out_coef  = r_pend_coef;
                    n_out_empty = 1'b0;
                    n_out_last  = 1'b0;
                    n_pend_exp  = r_term_exp;
                    n_pend_coef = r_term_coef;
                    n_state     = S_CMP;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_exp   = r_have_pend ? r_pend_exp : '0;
                    n_out_coef  = r_have_pend ? r_pend_coef : '0;
                    n_out_empty = !r_have_pend;
                    n_out_last  = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_sub       <= 1'b0;
            r_have_pend <= 1'b0;
            r_term_nz   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_sub       <= n_sub;
            r_have_pend <= n_have_pend;
            r_term_nz   <= n_term_nz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term_exp  <= n_term_exp;
        r_term_coef <= n_term_coef;
        r_pend_exp  <= n_pend_exp;
        r_pend_coef <= n_pend_coef;
        r_out_exp   <= n_out_exp;
        r_out_coef  <= n_out_coef;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    assign o_valid           = r_out_valid;
    assign o_out_exponent    = r_out_exp;
    assign o_out_coefficient = r_out_coef;
    assign o_is_empty        = r_out_empty;
    assign o_is_last         = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_polynomial_add_sub.sv =====
// Sparse polynomial add/subtract. Two term lists of up to MAX_TERMS
// (exponent, Q16.16 coefficient) pairs are loaded one term per transaction,
// and an add or subtract transaction merges them by exponent, emitting the
// non-zero saturated terms (in ascending order when both lists were loaded
// sorted) with is_last on the final one, or a single is_empty item when
// nothing survives. Clear and load transactions are taken one per cycle
// while the back end is idle. An add or subtract takes the back end through
// its steps in order: pop from the queue, read the list heads, then for each
// merge step a compare/saturate state and a push state (during which the
// list RAMs read the next heads), then a compare that finds both lists
// exhausted and a flush of the last term. The push and flush states wait
// while the output is stalled. A merge step consumes one head term or a
// matching pair. Input transactions keep flowing into a two-entry command
// queue while a merge runs; o_stall rises when that queue is full. Modes 5
// to 7 are accepted and ignored. Depends on spa_pkg and the spa_* modules.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_add_sub (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [2:0]                         i_mode,
    input  wire logic [spa_pkg::EXP_W-1:0]          i_exponent,
    input  wire logic signed [spa_pkg::COEF_W-1:0]  i_coefficient,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [spa_pkg::EXP_W-1:0]               o_out_exponent,
    output logic signed [spa_pkg::COEF_W-1:0]       o_out_coefficient,
    output logic                                    o_is_empty,
    output logic                                    o_is_last
);

    // front end -> queue
    logic              push;
    spa_pkg::t_cmd     push_cmd;
    logic              queue_full;

    // queue -> back end
    logic              cmd_valid;
    logic              cmd_pop;
    spa_pkg::t_cmd     cmd;

    // back end <-> list memories
    spa_pkg::t_list_wr             list_wr;
    logic [spa_pkg::IDX_W-1:0]     raddr_a, raddr_b;
    logic [spa_pkg::TERM_W-1:0]    rdata_a, rdata_b;

    spa_front u_front (
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_exponent    (i_exponent),
        .i_coefficient (i_coefficient),
        .i_queue_full  (queue_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    spa_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd)
    );

    // first list: exponent in the upper bits, coefficient below
    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::MAX_TERMS)
    ) u_list_a (
        .i_clk   (i_clk),
        .i_we    (list_wr.we_a),
        .i_waddr (list_wr.addr),
        .i_wdata (list_wr.data),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    // second list, same layout
    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::MAX_TERMS)
    ) u_list_b (
        .i_clk   (i_clk),
        .i_we    (list_wr.we_b),
        .i_waddr (list_wr.addr),
        .i_wdata (list_wr.data),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    spa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .o_wr              (list_wr),
        .o_raddr_a         (raddr_a),
        .o_raddr_b         (raddr_b),
        .i_rdata_a         (rdata_a),
        .i_rdata_b         (rdata_b),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_exponent    (o_out_exponent),
        .o_out_coefficient (o_out_coefficient),
        .o_is_empty        (o_is_empty),
        .o_is_last         (o_is_last)
    );

endmodule

`default_nettype wire

// ===== tb/sparse_polynomial_add_sub_test.sv =====
// Testbench for sparse_polynomial_add_sub: directed and random term loads and
// merges, checked result by result against an in-bench model of the merge.
// Depends on spa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module sparse_polynomial_add_sub_test;

    localparam int EXP_W           = spa_pkg::EXP_W;
    localparam int COEF_W          = spa_pkg::COEF_W;
    localparam int MAX_TERMS       = spa_pkg::MAX_TERMS;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int TAIL_CYCLES     = 200;  // longer than the longest merge
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 50;

    // mode codes that the block accepts and ignores
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [COEF_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic [EXP_W-1:0]         expo;
        logic signed [COEF_W-1:0] coef;
        logic                     empty;
        logic                     last;
    } t_term_result;

    typedef struct {
        logic [EXP_W-1:0]         expo;
        logic signed [COEF_W-1:0] coef;
    } t_term;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic [2:0]               i_mode        = spa_pkg::MODE_CLEAR;
    logic [EXP_W-1:0]         i_exponent    = '0;
    logic signed [COEF_W-1:0] i_coefficient = '0;
    logic                     i_stall       = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [EXP_W-1:0]         o_out_exponent;
    logic signed [COEF_W-1:0] o_out_coefficient;
    logic                     o_is_empty;
    logic                     o_is_last;

    // shadow copy of both term lists
    logic [EXP_W-1:0]         first_exp  [MAX_TERMS];
    logic signed [COEF_W-1:0] first_coef [MAX_TERMS];
    logic [EXP_W-1:0]         second_exp [MAX_TERMS];
    logic signed [COEF_W-1:0] second_coef[MAX_TERMS];
    int                       first_len  = 0;
    int                       second_len = 0;

    t_term_result pending_terms[$];

    int fail_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_off_left  = 0;

    sparse_polynomial_add_sub i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_exponent        (i_exponent),
        .i_coefficient     (i_coefficient),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_exponent    (o_out_exponent),
        .o_out_coefficient (o_out_coefficient),
        .o_is_empty        (o_is_empty),
        .o_is_last         (o_is_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Merge model
    // ------------------------------------------------------------------

    function automatic logic signed [COEF_W-1:0] clamp_q16(longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[COEF_W-1:0];
    endfunction

    // One ascending walk over both heads; equal exponents combine. Works
    // the same on unsorted lists, since only the heads are ever compared.
    task automatic merge_terms(bit subtract);
        int                       i = 0;
        int                       j = 0;
        logic [EXP_W-1:0]         e;
        longint                   s;
        logic signed [COEF_W-1:0] q;
        t_term_result             merged[$];
        t_term_result             r;
        while (i < first_len || j < second_len) begin
            if (i < first_len && j < second_len && first_exp[i] == second_exp[j]) begin
                e = first_exp[i];
                s = subtract ? longint'(first_coef[i]) - longint'(second_coef[j])
                             : longint'(first_coef[i]) + longint'(second_coef[j]);
                i++;
                j++;
            end else if (j >= second_len ||
                         (i < first_len && first_exp[i] < second_exp[j])) begin
                e = first_exp[i];
                s = longint'(first_coef[i]);
                i++;
            end else begin
                e = second_exp[j];
                s = subtract ? -longint'(second_coef[j]) : longint'(second_coef[j]);
                j++;
            end
            q = clamp_q16(s);
            if (q != 0) merged.push_back('{e, q, 1'b0, 1'b0});
        end
        if (merged.size() == 0) begin
            pending_terms.push_back('{'0, '0, 1'b1, 1'b1});
        end else begin
            merged[merged.size()-1].last = 1'b1;
            foreach (merged[k]) begin
                r = merged[k];
                pending_terms.push_back(r);
            end
        end
    endtask

    task automatic predict_transaction(logic [2:0] mode, logic [EXP_W-1:0] expo,
                                       logic signed [COEF_W-1:0] coef);
        case (mode)
            spa_pkg::MODE_CLEAR: begin
                first_len  = 0;
                second_len = 0;
            end
            spa_pkg::MODE_LOAD_A: begin
                if (first_len < MAX_TERMS) begin
                    first_exp[first_len]  = expo;
                    first_coef[first_len] = coef;
                    first_len++;
                end
            end
            spa_pkg::MODE_LOAD_B: begin
                if (second_len < MAX_TERMS) begin
                    second_exp[second_len]  = expo;
                    second_coef[second_len] = coef;
                    second_len++;
                end
            end
            spa_pkg::MODE_ADD: merge_terms(1'b0);
            spa_pkg::MODE_SUB: merge_terms(1'b1);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drives one transaction, with random idle cycles ahead of it, and
    // predicts its results once the block has taken it.
    task automatic send_term(logic [2:0] mode, logic [EXP_W-1:0] expo,
                             logic signed [COEF_W-1:0] coef);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_exponent    <= expo;
        i_coefficient <= coef;
        do @(posedge i_clk); while (o_stall);
        predict_transaction(mode, expo, coef);
    endtask

    // Sender pauses until every predicted result has been seen.
    task automatic wait_for_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_terms.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef;
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return $signed(COEF_W'($urandom_range(4))) - 2;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_term_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_terms.size() == 0) begin
                $error("unexpected result: out_exponent %0d out_coefficient %0d",
                       o_out_exponent, o_out_coefficient);
                fail_count++;
            end else begin
                want = pending_terms.pop_front();
                if (o_out_exponent !== want.expo) begin
                    $error("out_exponent: expected %0d, got %0d", want.expo,
                           o_out_exponent);
                    fail_count++;
                end
                if (o_out_coefficient !== want.coef) begin
                    $error("out_coefficient: expected %0d, got %0d", want.coef,
                           o_out_coefficient);
                    fail_count++;
                end
                if (o_is_empty !== want.empty) begin
                    $error("is_empty: expected %0b, got %0b", want.empty, o_is_empty);
                    fail_count++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, o_is_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_terms.size());
            $display("sparse_polynomial_add_sub verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty lists, saturation both ways, cancellation, zero terms, spare
    // modes and clear.
    task automatic test_directed_extremes;
        send_term(spa_pkg::MODE_ADD, '0, '0);   // nothing loaded: empty result
        send_term(spa_pkg::MODE_SUB, '1, '1);
        send_term(spa_pkg::MODE_LOAD_A, 16'd0,     Q_MAX);
        send_term(spa_pkg::MODE_LOAD_A, 16'd5,     Q_ONE);
        send_term(spa_pkg::MODE_LOAD_A, 16'd65535, Q_MIN);
        send_term(spa_pkg::MODE_LOAD_B, 16'd0,     32'sd1);
        send_term(spa_pkg::MODE_LOAD_B, 16'd5,     Q_ONE);
        send_term(spa_pkg::MODE_LOAD_B, 16'd7,     '0);
        send_term(spa_pkg::MODE_LOAD_B, 16'd65534, Q_MIN);   // negated on subtract: clamps
        send_term(spa_pkg::MODE_LOAD_B, 16'd65535, Q_MIN);
        send_term(spa_pkg::MODE_ADD, '0, '0);   // top clamps high, bottom clamps low
        send_term(spa_pkg::MODE_SUB, '0, '0);   // equal terms cancel and drop
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_term(3'(m), '1, Q_MIN);
        send_term(spa_pkg::MODE_CLEAR, '0, '0);
        send_term(spa_pkg::MODE_ADD, '0, '0);
        wait_for_results();
    endtask

    // Lists loaded out of order: the walk takes whichever head is lower.
    task automatic test_unsorted_load;
        send_term(spa_pkg::MODE_CLEAR, '0, '0);
        send_term(spa_pkg::MODE_LOAD_A, 16'd10, 32'sd1);
        send_term(spa_pkg::MODE_LOAD_A, 16'd3,  32'sd2);
        send_term(spa_pkg::MODE_LOAD_B, 16'd3,  32'sd4);
        send_term(spa_pkg::MODE_ADD, '0, '0);
        wait_for_results();
    endtask

    // Both lists overfilled (extra loads dropped), then a run of merges of
    // 64 terms each while the receiver holds off, so the command queue fills
    // and the input stalls.
    task automatic test_backpressure;
        send_term(spa_pkg::MODE_CLEAR, '0, '0);
        for (int k = 0; k < MAX_TERMS + 2; k++) begin
            send_term(spa_pkg::MODE_LOAD_A, EXP_W'(2 * k),     $urandom | 1);
            send_term(spa_pkg::MODE_LOAD_B, EXP_W'(2 * k + 1), $urandom | 1);
        end
        hold_off_left = HOLD_OFF_CYCLES;
        send_term(spa_pkg::MODE_ADD, '0, '0);
        send_term(spa_pkg::MODE_SUB, '0, '0);
        send_term(spa_pkg::MODE_ADD, '0, '0);
        send_term(spa_pkg::MODE_SUB, '0, '0);
        send_term(spa_pkg::MODE_LOAD_A, 16'd100, Q_ONE);   // ignored, list full
        wait_for_results();
    endtask

    // One sequence: usually a clear, two lists built from a common exponent
    // walk so that matches are frequent, then one or two merges. Now and
    // then the clear is skipped, a list is scrambled or a spare mode slips in.
    task automatic run_merge_sequence(inout int sent);
        t_term first_terms[$];
        t_term second_terms[$];
        t_term t;
        t_term swap;
        int    n_steps;
        int    step_max;
        int    e;
        int    which;
        bit    pick_first;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        n_steps  = ($urandom_range(99) < 3) ? $urandom_range(40, 56) : $urandom_range(0, 8);
        step_max = $urandom_range(1) ? 3 : 65535 / (n_steps + 1);
        e        = $urandom_range(0, step_max);
        for (int k = 0; k < n_steps && e <= 65535; k++) begin
            which = $urandom_range(2);
            a     = pick_coef();
            case ($urandom_range(2))
                0: b = a;
                1: b = -a;
                default: b = pick_coef();
            endcase
            if (which != 1) first_terms.push_back('{EXP_W'(e), a});
            if (which != 0) second_terms.push_back('{EXP_W'(e), b});
            e += $urandom_range(1, step_max);
        end
        if (first_terms.size() >= 2 && $urandom_range(9) == 0) begin
            swap = first_terms[0];
            first_terms[0] = first_terms[first_terms.size()-1];
            first_terms[first_terms.size()-1] = swap;
        end
        if ($urandom_range(99) < 85) begin
            send_term(spa_pkg::MODE_CLEAR, EXP_W'($urandom), $urandom);
            sent++;
        end
        while (first_terms.size() + second_terms.size() != 0) begin
            pick_first = (second_terms.size() == 0) ||
                         (first_terms.size() != 0 && $urandom_range(1));
            if (pick_first) begin
                t = first_terms.pop_front();
                if (first_len < MAX_TERMS) sent++;
                send_term(spa_pkg::MODE_LOAD_A, t.expo, t.coef);
            end else begin
                t = second_terms.pop_front();
                if (second_len < MAX_TERMS) sent++;
                send_term(spa_pkg::MODE_LOAD_B, t.expo, t.coef);
            end
            if ($urandom_range(49) == 0)
                send_term(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                          EXP_W'($urandom), $urandom);
        end
        repeat ($urandom_range(1, 2)) begin
            send_term($urandom_range(1) ? spa_pkg::MODE_ADD : spa_pkg::MODE_SUB,
                      EXP_W'($urandom), $urandom);
            sent++;
        end
    endtask

    task automatic test_random_merges(int sender_pct, int receiver_pct);
        int sent = 0;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        while (sent < PHASE_ITEMS) run_merge_sequence(sent);
        wait_for_results();
    endtask

    initial begin
        send_idle_pct = 35;
        recv_idle_pct = 48;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_unsorted_load();
        test_random_merges(35, 48);
        test_random_merges(48, 35);
        test_random_merges(0, 0);
        test_backpressure();

        // catch anything the block emits after the last expected term
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_terms.size() == 0) begin
            $display("sparse_polynomial_add_sub verification clean");
        end else begin
            $display("sparse_polynomial_add_sub verification failed");
        end
        $finish;
    end

endmodule
